@@ src/crp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg
// Types and codes shared by the colour ramp interpolator and its divider.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic CFG_NUM_ENTRIES  = 1'b0;
  localparam logic CFG_INTERP_SHIFT = 1'b1;

  localparam logic [4:0] NUM_ENTRIES_RST  = 5'd2;
  localparam logic [3:0] INTERP_SHIFT_RST = 4'd5;

  // two quotient bits per divider stage over a 32-bit dividend
  localparam int DIV_STAGES = 16;

  typedef struct packed {
    logic               op;
    logic [3:0]         entry_index;
    logic signed [15:0] entry_height;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
    logic signed [15:0] height;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  typedef struct packed {
    logic [15:0] h;
    color_t      c;
  } entry_t;

  // colours and fraction override travelling beside the divider
  typedef struct packed {
    logic   zero;
    color_t lo;
    color_t hi;
  } side_t;

endpackage

@@ src/crp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_div
// Pipelined restoring divider, two quotient bits per stage, low 16 bits of
// the quotient kept, with side data carried alongside.
// ----------------------------------------------------------------------------
module crp_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld,
  input  logic [31:0]          dividend,
  input  logic [15:0]          divisor,
  input  crp_pkg::side_t       side,
  output logic                 quot_vld,
  output logic [15:0]          quot,
  output crp_pkg::side_t       quot_side
);

  localparam int NS = crp_pkg::DIV_STAGES;

  logic                 vld_a  [0:NS];
  logic [15:0]          rem_a  [0:NS];
  logic [31:0]          dvd_a  [0:NS];
  logic [15:0]          q_a    [0:NS];
  logic [15:0]          den_a  [0:NS];
  crp_pkg::side_t       side_a [0:NS];

  function automatic logic [16:0] div_step(input logic [15:0] rem, input logic b,
                                           input logic [15:0] den);
    logic [16:0] t;
    begin
      t = {rem, b};
      if (t >= {1'b0, den}) begin
        div_step = {1'b1, 16'(t - {1'b0, den})};
      end else begin
        div_step = {1'b0, t[15:0]};
      end
    end
  endfunction

  assign vld_a[0]  = vld;
  assign rem_a[0]  = '0;
  assign dvd_a[0]  = dividend;
  assign q_a[0]    = '0;
  assign den_a[0]  = divisor;
  assign side_a[0] = side;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [16:0] st_a;
    logic [16:0] st_b;

    assign st_a = div_step(rem_a[s], dvd_a[s][31], den_a[s]);
    assign st_b = div_step(st_a[15:0], dvd_a[s][30], den_a[s]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[s+1] <= 1'b0;
      end else if (en) begin
        vld_a[s+1] <= vld_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[s+1]  <= st_b[15:0];
        dvd_a[s+1]  <= {dvd_a[s][29:0], 2'b00};
        q_a[s+1]    <= {q_a[s][13:0], st_a[16], st_b[16]};
        den_a[s+1]  <= den_a[s];
        side_a[s+1] <= side_a[s];
      end
    end
  end

  assign quot_vld  = vld_a[NS];
  assign quot      = q_a[NS];
  assign quot_side = side_a[NS];

endmodule

@@ src/color_ramp_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_ramp_interpolator
// Maps a signed height to an RGB colour by linear interpolation along a
// ramp of stored breakpoints.
// ----------------------------------------------------------------------------
// in_data carries one item per transfer: op OP_WRITE loads breakpoint
// entry_index, op OP_LOOKUP colours height. Writes give no result; each
// lookup gives one out_data transfer, in order.
// Configuration (cfg_index 0 = num_entries, 1 = interp_shift) is written
// over the cfg channel, always ready; the user must write it only while
// the pipeline is empty, which the block itself does not enforce. The item
// passes 20 registers (input register, segment select, 16 divider stages
// of two quotient bits each, blend multiply, output register), the first
// loaded at the transfer edge. One item enters per cycle unless stalled.
// The whole pipeline advances as one; when out_valid is high and out_stall
// is high, every stage holds and in_stall is raised, so nothing is lost.
// Reset clears all valid bits and sets num_entries to 2, interp_shift to 5;
// breakpoints are undefined until written.
// ----------------------------------------------------------------------------
module color_ramp_interpolator #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  crp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output crp_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [4:0]     cfg_data
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  logic       en;
  logic [4:0] num_entries;
  logic [3:0] interp_shift;

  crp_pkg::entry_t tbl [0:MAX_ENTRIES-1];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries  <= crp_pkg::NUM_ENTRIES_RST;
      interp_shift <= crp_pkg::INTERP_SHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        crp_pkg::CFG_NUM_ENTRIES:  num_entries  <= cfg_data;
        crp_pkg::CFG_INTERP_SHIFT: interp_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // stage 1: input register
  logic         v1;
  crp_pkg::in_t d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= in_data;
    end
  end

  // breakpoint writes take effect as they leave stage 1, keeping item order
  always_ff @(posedge clk) begin
    if (en && v1 && d1.op == crp_pkg::OP_WRITE && 32'(d1.entry_index) < MAX_ENTRIES) begin
      tbl[IW'(d1.entry_index)] <= {d1.entry_height, d1.entry_red, d1.entry_green,
                                   d1.entry_blue};
    end
  end

  // segment search
  logic [NW-1:0]   n_sat;
  logic [IW-1:0]   top_idx;
  logic [IW-1:0]   seg;
  logic            found;
  logic            top_hit;
  crp_pkg::entry_t sel_lo;
  crp_pkg::entry_t sel_hi;
  logic            sel_zero;

  always_comb begin
    if (num_entries < 5'd2) begin
      n_sat = NW'(2);
    end else if (32'(num_entries) > MAX_ENTRIES) begin
      n_sat = NW'(MAX_ENTRIES);
    end else begin
      n_sat = NW'(num_entries);
    end
    top_idx = IW'(n_sat - NW'(1));
    top_hit = d1.height >= $signed(tbl[top_idx].h);
    seg     = '0;
    found   = 1'b0;
    for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
      if (k + 1 < int'(n_sat) && d1.height >= $signed(tbl[k].h)) begin
        seg   = IW'(k);
        found = 1'b1;
      end
    end
    if (top_hit) begin
      sel_lo   = tbl[top_idx];
      sel_hi   = tbl[top_idx];
      sel_zero = 1'b1;
    end else if (found) begin
      sel_lo   = tbl[seg];
      sel_hi   = tbl[IW'(seg + IW'(1))];
      sel_zero = 1'b0;
    end else begin
      sel_lo   = tbl[0];
      sel_hi   = tbl[0];
      sel_zero = 1'b1;
    end
  end

  // stage 2: selected segment
  logic               v2;
  logic signed [15:0] h2;
  crp_pkg::entry_t    lo2;
  crp_pkg::entry_t    hi2;
  logic               zero2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1 && d1.op == crp_pkg::OP_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2    <= d1.height;
      lo2   <= sel_lo;
      hi2   <= sel_hi;
      zero2 <= sel_zero;
    end
  end

  logic [15:0]    num;
  logic [15:0]    den;
  logic [31:0]    dividend;
  crp_pkg::side_t side2;

  assign num      = 16'(h2 - $signed(lo2.h));
  assign den      = 16'(hi2.h - lo2.h);
  assign dividend = {16'b0, num} << interp_shift;
  assign side2    = '{zero: zero2 || den == 16'd0, lo: lo2.c, hi: hi2.c};

  logic           qv;
  logic [15:0]    q;
  crp_pkg::side_t qside;

  crp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vld       (v2),
    .dividend  (dividend),
    .divisor   (den),
    .side      (side2),
    .quot_vld  (qv),
    .quot      (q),
    .quot_side (qside)
  );

  // blend multiply
  logic [15:0] f;
  logic [15:0] of;
  logic [16:0] scale;

  assign scale = 17'd1 << interp_shift;
  assign f     = qside.zero ? 16'd0 : q;
  assign of    = 16'(scale - {1'b0, f});

  logic        vm;
  logic [24:0] acc_r;
  logic [24:0] acc_g;
  logic [24:0] acc_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= 25'(f * qside.hi.r) + 25'(of * qside.lo.r);
      acc_g <= 25'(f * qside.hi.g) + 25'(of * qside.lo.g);
      acc_b <= 25'(f * qside.hi.b) + 25'(of * qside.lo.b);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.red   <= 8'(acc_r >> interp_shift);
      out_data.green <= 8'(acc_g >> interp_shift);
      out_data.blue  <= 8'(acc_b >> interp_shift);
    end
  end

endmodule
